>>> sv/rmag_pkg.sv
`default_nettype none
package rmag_pkg;

   // chip state word values
   localparam logic [31:0] ST_RESTRICTED = 32'h494E_4954;
   localparam logic [31:0] ST_OVERRIDDEN = ~ST_RESTRICTED;

   // response word values
   localparam logic [31:0] RSP_STARTED = 32'hFEED_DA7A;
   localparam logic [31:0] RSP_BURST   = 32'h0ACC_E55B;
   localparam logic [31:0] RSP_GRANTED = 32'h00AC_CE55;
   localparam logic [31:0] RSP_DENIED  = 32'hBAAD_BAAD;

   localparam logic [9:0] TIMEOUT_RESET = 10'd5;

   typedef enum logic [1:0] {
      MODE_ACCESS   = 2'd0,
      MODE_RESPONSE = 2'd1,
      MODE_TICK     = 2'd2,
      MODE_UNUSED   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ACT_ALLOWED = 3'd0,
      ACT_ISSUED  = 3'd1,
      ACT_WAITING = 3'd2,
      ACT_GRANTED = 3'd3,
      ACT_DENIED  = 3'd4,
      ACT_TIMEOUT = 3'd5,
      ACT_UNKNOWN = 3'd6,
      ACT_IGNORED = 3'd7
   } action_type;

   typedef enum logic [2:0] {
      REG_RESET_ADDR   = 3'd0,
      REG_EXPAND_START = 3'd1,
      REG_EXPAND_END   = 3'd2,
      REG_TIMEOUT      = 3'd3,
      REG_FIXED0_START = 3'd4,
      REG_FIXED0_END   = 3'd5,
      REG_FIXED1_START = 3'd6,
      REG_FIXED1_END   = 3'd7
   } reg_index_type;

   // access [a, a+n) inside [s, e), with no wrap past the top of memory
   function automatic logic in_region(input logic [31:0] a, input logic [31:0] n,
                                      input logic [31:0] s, input logic [31:0] e);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, n};
      return !sum[32] && (a >= s) && (a < e) && (sum[31:0] <= e);
   endfunction

endpackage
`default_nettype wire

>>> sv/rmag_req_if.sv
`default_nettype none
interface rmag_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [31:0] access_address;
   logic [30:0] access_length;
   logic        device_powered;
   logic [31:0] chip_state_word;
   logic [31:0] response_word;

   modport source (output valid, output mode, output access_address,
                   output access_length, output device_powered,
                   output chip_state_word, output response_word, input ready);
   modport sink (input valid, input mode, input access_address,
                 input access_length, input device_powered,
                 input chip_state_word, input response_word, output ready);
endinterface
`default_nettype wire

>>> sv/rmag_rsp_if.sv
`default_nettype none
interface rmag_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [31:0] request_address;
   logic [31:0] request_length;
   logic        burst_granted;

   modport source (output valid, output action, output request_address,
                   output request_length, output burst_granted, input ready);
   modport sink (input valid, input action, input request_address,
                 input request_length, input burst_granted, output ready);
endinterface
`default_nettype wire

>>> sv/restricted_memory_access_gate_top.sv
// a request taken into the request register gives its result in the result register
// throughput: one request per cycle unless a held result waits on rsp_ch.ready; the gate state
// updates between the request register and the result register
// reset (synchronous, active high): flags, cache, pending request and tick count clear,
// timeout register returns to 5, all other csr registers to 0
`default_nettype none
module restricted_memory_access_gate_top (
   input  wire          clock,
   input  wire          reset,
   rmag_req_if.sink     req_ch,
   rmag_rsp_if.source   rsp_ch,
   input  wire          csr_write_enable,
   input  wire  [2:0]   csr_index,
   input  wire  [31:0]  csr_write_data
);

   // csr registers
   logic [31:0] reset_addr_ff, expand_start_ff, expand_end_ff;
   logic [31:0] fixed0_start_ff, fixed0_end_ff, fixed1_start_ff, fixed1_end_ff;
   logic [9:0]  timeout_ff;

   // request register
   logic        in_valid_ff;
   logic [1:0]  in_mode_ff;
   logic [31:0] in_addr_ff;
   logic [30:0] in_len_ff;
   logic        in_powered_ff;
   logic [31:0] in_state_word_ff;
   logic [31:0] in_rsp_word_ff;

   // gate state
   logic        enforced_ff, enforced_in;
   logic        overridden_ff, overridden_in;
   logic        awaiting_ff, awaiting_in;
   logic [31:0] cached_start_ff, cached_start_in;
   logic [31:0] cached_end_ff, cached_end_in;
   logic [31:0] pending_start_ff, pending_start_in;
   logic [31:0] pending_len_ff, pending_len_in;
   logic [9:0]  wait_ticks_ff, wait_ticks_in;

   // result register
   logic        out_valid_ff;
   logic [2:0]  out_action_ff;
   logic [31:0] out_addr_ff, out_len_ff;
   logic        out_burst_ff;

   rmag_pkg::action_type action_in;
   logic [31:0] res_addr_in, res_len_in;
   logic        res_burst_in;

   logic        advance;
   logic        take;

   // the pipe moves whenever the result slot is free or being emptied
   assign advance       = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready  = !in_valid_ff || advance;
   assign take          = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.action          = out_action_ff;
   assign rsp_ch.request_address = out_addr_ff;
   assign rsp_ch.request_length  = out_len_ff;
   assign rsp_ch.burst_granted   = out_burst_ff;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         reset_addr_ff   <= '0;
         expand_start_ff <= '0;
         expand_end_ff   <= '0;
         timeout_ff      <= rmag_pkg::TIMEOUT_RESET;
         fixed0_start_ff <= '0;
         fixed0_end_ff   <= '0;
         fixed1_start_ff <= '0;
         fixed1_end_ff   <= '0;
      end else if (csr_write_enable) begin
         case (rmag_pkg::reg_index_type'(csr_index))
            rmag_pkg::REG_RESET_ADDR:   reset_addr_ff   <= csr_write_data;
            rmag_pkg::REG_EXPAND_START: expand_start_ff <= csr_write_data;
            rmag_pkg::REG_EXPAND_END:   expand_end_ff   <= csr_write_data;
            rmag_pkg::REG_TIMEOUT:      timeout_ff      <= csr_write_data[9:0];
            rmag_pkg::REG_FIXED0_START: fixed0_start_ff <= csr_write_data;
            rmag_pkg::REG_FIXED0_END:   fixed0_end_ff   <= csr_write_data;
            rmag_pkg::REG_FIXED1_START: fixed1_start_ff <= csr_write_data;
            rmag_pkg::REG_FIXED1_END:   fixed1_end_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // request register: control under reset, payload free running on take
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_mode_ff       <= req_ch.mode;
         in_addr_ff       <= req_ch.access_address;
         in_len_ff        <= req_ch.access_length;
         in_powered_ff    <= req_ch.device_powered;
         in_state_word_ff <= req_ch.chip_state_word;
         in_rsp_word_ff   <= req_ch.response_word;
      end
   end

   // decision logic for the request in the request register
   always_comb begin
      logic        enf_on;
      logic        in_fixed;
      logic [31:0] len32;
      logic [9:0]  tick_count;

      enforced_in      = enforced_ff;
      overridden_in    = overridden_ff;
      awaiting_in      = awaiting_ff;
      cached_start_in  = cached_start_ff;
      cached_end_in    = cached_end_ff;
      pending_start_in = pending_start_ff;
      pending_len_in   = pending_len_ff;
      wait_ticks_in    = wait_ticks_ff;
      action_in        = rmag_pkg::ACT_IGNORED;
      res_addr_in      = '0;
      res_len_in       = '0;
      res_burst_in     = 1'b0;

      len32      = {1'b0, in_len_ff};
      tick_count = wait_ticks_ff + 10'd1;
      in_fixed   = rmag_pkg::in_region(in_addr_ff, len32, fixed0_start_ff, fixed0_end_ff) ||
                   rmag_pkg::in_region(in_addr_ff, len32, fixed1_start_ff, fixed1_end_ff);

      // enforcement refresh from the chip state word
      enf_on = 1'b0;
      if (overridden_ff) begin
         enf_on = 1'b0;
      end else if (in_powered_ff && enforced_ff) begin
         enf_on = 1'b1;
      end else if (in_state_word_ff == rmag_pkg::ST_RESTRICTED) begin
         enf_on = 1'b1;
      end else begin
         enf_on = 1'b0;
      end

      case (rmag_pkg::mode_type'(in_mode_ff))
         rmag_pkg::MODE_ACCESS: begin
            if (!awaiting_ff) begin
               if (!overridden_ff && !(in_powered_ff && enforced_ff)) begin
                  enforced_in   = enf_on;
                  overridden_in = (in_state_word_ff == rmag_pkg::ST_OVERRIDDEN);
               end
               if (!enf_on) begin
                  action_in = rmag_pkg::ACT_ALLOWED;
               end else if (in_fixed) begin
                  // access to the reset register drops enforcement and the cache
                  if (in_addr_ff == reset_addr_ff) begin
                     enforced_in     = 1'b0;
                     cached_start_in = '0;
                     cached_end_in   = '0;
                  end
                  action_in = rmag_pkg::ACT_ALLOWED;
               end else if (rmag_pkg::in_region(in_addr_ff, len32,
                                                cached_start_ff, cached_end_ff)) begin
                  action_in = rmag_pkg::ACT_ALLOWED;
               end else begin
                  if (rmag_pkg::in_region(in_addr_ff, len32,
                                          expand_start_ff, expand_end_ff)) begin
                     res_addr_in = expand_start_ff;
                     res_len_in  = expand_end_ff - expand_start_ff;
                  end else begin
                     res_addr_in = in_addr_ff;
                     res_len_in  = len32;
                  end
                  pending_start_in = res_addr_in;
                  pending_len_in   = res_len_in;
                  awaiting_in      = 1'b1;
                  wait_ticks_in    = '0;
                  action_in        = rmag_pkg::ACT_ISSUED;
               end
            end
         end
         rmag_pkg::MODE_RESPONSE: begin
            if (awaiting_ff) begin
               res_addr_in = pending_start_ff;
               res_len_in  = pending_len_ff;
               if (in_rsp_word_ff == rmag_pkg::RSP_STARTED) begin
                  action_in = rmag_pkg::ACT_WAITING;
               end else begin
                  awaiting_in = 1'b0;
                  if (in_rsp_word_ff == rmag_pkg::RSP_BURST ||
                      in_rsp_word_ff == rmag_pkg::RSP_GRANTED) begin
                     cached_start_in = pending_start_ff;
                     cached_end_in   = pending_start_ff + pending_len_ff;
                     res_burst_in    = (in_rsp_word_ff == rmag_pkg::RSP_BURST);
                     action_in       = rmag_pkg::ACT_GRANTED;
                  end else if (in_rsp_word_ff == rmag_pkg::RSP_DENIED) begin
                     action_in = rmag_pkg::ACT_DENIED;
                  end else begin
                     action_in = rmag_pkg::ACT_UNKNOWN;
                  end
               end
            end
         end
         rmag_pkg::MODE_TICK: begin
            if (awaiting_ff) begin
               res_addr_in   = pending_start_ff;
               res_len_in    = pending_len_ff;
               wait_ticks_in = tick_count;
               // a timeout of zero trips on the first tick, same as one
               if (tick_count >= timeout_ff) begin
                  awaiting_in = 1'b0;
                  action_in   = rmag_pkg::ACT_TIMEOUT;
               end else begin
                  action_in = rmag_pkg::ACT_WAITING;
               end
            end
         end
         default: begin
            action_in = rmag_pkg::ACT_IGNORED;
         end
      endcase
   end

   // gate state commits when the request moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         enforced_ff      <= 1'b0;
         overridden_ff    <= 1'b0;
         awaiting_ff      <= 1'b0;
         cached_start_ff  <= '0;
         cached_end_ff    <= '0;
         pending_start_ff <= '0;
         pending_len_ff   <= '0;
         wait_ticks_ff    <= '0;
      end else if (in_valid_ff && advance) begin
         enforced_ff      <= enforced_in;
         overridden_ff    <= overridden_in;
         awaiting_ff      <= awaiting_in;
         cached_start_ff  <= cached_start_in;
         cached_end_ff    <= cached_end_in;
         pending_start_ff <= pending_start_in;
         pending_len_ff   <= pending_len_in;
         wait_ticks_ff    <= wait_ticks_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff && advance) begin
         out_action_ff <= action_in;
         out_addr_ff   <= res_addr_in;
         out_len_ff    <= res_len_in;
         out_burst_ff  <= res_burst_in;
      end
   end

endmodule
`default_nettype wire
